FILE: hdl/acic_pkg.sv
package acic_pkg;

    localparam int MV_W       = 12;
    localparam int TYPE_W     = 10;
    localparam int REQ_W      = 2;
    localparam int IDX_W      = 3;
    localparam int STAT_W     = 2;
    localparam int TCNT_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [MV_W-1:0] DIFF_THR_RST = 12'd100;
    localparam logic [MV_W-1:0] ABN_V_RST    = 12'd1800;

    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_TABLE  = 2'd1,
        REQ_START  = 2'd2
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_MATCH   = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_INVALID = 2'd2,
        ST_ADCFAIL = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_COUNT = 3'd0,
        CFG_EMB_BATT    = 3'd1,
        CFG_FACT_BOOT   = 3'd2,
        CFG_DIFF_THR    = 3'd3,
        CFG_ABN_VOLT    = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_F_DIFF,
        S_F_CMP,
        S_C_LOOP,
        S_C_CMP,
        S_CLASSIFY,
        S_T_ADDR,
        S_T_LO,
        S_T_HI,
        S_FAIL,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [MV_W-1:0]   lo;
        logic [MV_W-1:0]   hi;
        logic [TYPE_W-1:0] code;
    } range_entry_t;

    typedef struct packed {
        logic            lt;
        logic [MV_W-1:0] mag;
    } cmp_res_t;

endpackage

FILE: hdl/acic_req_if.sv
interface acic_req_if;
    import acic_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [MV_W-1:0]   adc_mv;
    logic              adc_fail;
    logic              cable_valid;
    logic [IDX_W-1:0]  entry_index;
    logic [MV_W-1:0]   entry_min;
    logic [MV_W-1:0]   entry_max;
    logic [TYPE_W-1:0] entry_type;

    modport source (
        output valid, req_type, adc_mv, adc_fail, cable_valid,
               entry_index, entry_min, entry_max, entry_type,
        input  ready
    );

    modport sink (
        input  valid, req_type, adc_mv, adc_fail, cable_valid,
               entry_index, entry_min, entry_max, entry_type,
        output ready
    );

endinterface

FILE: hdl/acic_res_if.sv
interface acic_res_if;
    import acic_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [TYPE_W-1:0] cable_type;
    logic [MV_W-1:0]   voltage_mv;

    modport source (
        output valid, status, cable_type, voltage_mv,
        input  ready
    );

    modport sink (
        input  valid, status, cable_type, voltage_mv,
        output ready
    );

endinterface

FILE: hdl/acic_cmp_unit.sv
module acic_cmp_unit (
    input  logic [acic_pkg::MV_W-1:0] a,
    input  logic [acic_pkg::MV_W-1:0] b,
    output acic_pkg::cmp_res_t        res
);
    import acic_pkg::*;

    logic [MV_W:0] diff;

    // a - b with borrow; magnitude is |a - b|
    assign diff    = {1'b0, a} - {1'b0, b};
    assign res.lt  = diff[MV_W];
    assign res.mag = diff[MV_W] ? (MV_W'(0) - diff[MV_W-1:0]) : diff[MV_W-1:0];

endmodule

FILE: hdl/acic_table.sv
module acic_table #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  acic_pkg::range_entry_t wr_data,
    input  logic [AW-1:0]          rd_addr,
    output acic_pkg::range_entry_t rd_data
);
    import acic_pkg::*;

    range_entry_t mem [DEPTH];
    range_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/adc_cable_id_classifier.sv
// channel  | modport | payload
// req_ch   | sink    | req_type adc_mv adc_fail cable_valid entry_index entry_min
//          |         | entry_max entry_type
// res_ch   | source  | status cable_type voltage_mv
// cfg      | write   | cfg_we cfg_addr cfg_wdata
//
// Table writes, valid starts and ignored items end at decode (S_DISPATCH). A
// sample adds a pair compare (S_F_*) or, in check mode, a history compare per
// entry (S_C_*), S_CLASSIFY, S_T_* per range entry (up to TABLE_DEPTH), S_FAIL
// per failed attempt and S_EMIT per result; one shared subtract/compare unit.
// Reset loads config defaults and clears history, counters and current
// type/voltage. A result not yet taken holds the block in S_EMIT, stalling input.
module adc_cable_id_classifier #(
    parameter int TABLE_DEPTH = 8,
    parameter int MAX_SAMPLES = 4,
    parameter int RETRY_LIMIT = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    acic_req_if.sink                          req_ch,
    acic_res_if.source                        res_ch,
    input  logic                              cfg_we,
    input  logic [acic_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [acic_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import acic_pkg::*;

    localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NCW = ($clog2(TABLE_DEPTH + 1) > TCNT_W) ?
                         $clog2(TABLE_DEPTH + 1) : TCNT_W;
    localparam int HIW = $clog2(MAX_SAMPLES);
    localparam int SCW = $clog2(2 * MAX_SAMPLES);
    localparam int ACW = $clog2(RETRY_LIMIT + 1);

    // configuration
    logic [TCNT_W-1:0] tcount_reg;
    logic              emb_reg;
    logic              fboot_reg;
    logic [MV_W-1:0]   thr_reg;
    logic [MV_W-1:0]   abn_reg;

    // latched item
    req_t              it_req_reg;
    logic [MV_W-1:0]   it_adc_reg;
    logic              it_fail_reg;
    logic              it_valid_reg;
    logic [IDX_W-1:0]  it_idx_reg;
    logic [MV_W-1:0]   it_min_reg;
    logic [MV_W-1:0]   it_max_reg;
    logic [TYPE_W-1:0] it_type_reg;

    state_t            state_reg, state_next;
    logic              meas_reg, meas_next;
    logic [SCW-1:0]    cnt_reg, cnt_next;
    logic [ACW-1:0]    att_reg, att_next;
    logic [TYPE_W-1:0] cur_type_reg, cur_type_next;
    logic [MV_W-1:0]   cur_v_reg, cur_v_next;
    logic [MV_W-1:0]   hist_reg [MAX_SAMPLES];
    logic              hist_we;
    logic [HIW-1:0]    hist_wa;
    logic [SCW-1:0]    idx_reg, idx_next;
    logic [NCW-1:0]    tidx_reg, tidx_next;
    logic [MV_W-1:0]   d_reg, d_next;
    logic [MV_W-1:0]   v_reg, v_next;
    status_t           stat_reg, stat_next;
    logic              ov_reg, ov_next;
    status_t           o_stat_reg, o_stat_next;
    logic [TYPE_W-1:0] o_type_reg, o_type_next;
    logic [MV_W-1:0]   o_v_reg, o_v_next;

    logic [MV_W-1:0]   cmp_a, cmp_b;
    cmp_res_t          cmp_res;
    logic              tbl_we;
    range_entry_t      tbl_wdata;
    range_entry_t      tbl_rdata;
    logic [NCW-1:0]    n_eff;
    logic [SCW-1:0]    cnt_eff;
    logic [ACW-1:0]    att_inc;
    logic [NCW-1:0]    tidx_inc;
    logic              req_acc;

    acic_cmp_unit u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    acic_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (TAW)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_addr (TAW'(it_idx_reg)),
        .wr_data (tbl_wdata),
        .rd_addr (tidx_reg[TAW-1:0]),
        .rd_data (tbl_rdata)
    );

    assign req_acc      = req_ch.valid && req_ch.ready;
    assign req_ch.ready = (state_reg == S_IDLE);

    assign res_ch.valid      = ov_reg;
    assign res_ch.status     = o_stat_reg;
    assign res_ch.cable_type = o_type_reg;
    assign res_ch.voltage_mv = o_v_reg;

    assign tbl_wdata.lo   = it_min_reg;
    assign tbl_wdata.hi   = it_max_reg;
    assign tbl_wdata.code = it_type_reg;

    assign n_eff    = (NCW'(tcount_reg) > NCW'(TABLE_DEPTH)) ? NCW'(TABLE_DEPTH)
                                                             : NCW'(tcount_reg);
    assign cnt_eff  = (cnt_reg >= SCW'(MAX_SAMPLES)) ? SCW'(MAX_SAMPLES - 1) : cnt_reg;
    assign att_inc  = att_reg + ACW'(1);
    assign tidx_inc = tidx_reg + NCW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcount_reg <= '0;
            emb_reg    <= 1'b0;
            fboot_reg  <= 1'b0;
            thr_reg    <= DIFF_THR_RST;
            abn_reg    <= ABN_V_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_TABLE_COUNT: tcount_reg <= cfg_wdata[TCNT_W-1:0];
                CFG_EMB_BATT:    emb_reg    <= cfg_wdata[0];
                CFG_FACT_BOOT:   fboot_reg  <= cfg_wdata[0];
                CFG_DIFF_THR:    thr_reg    <= cfg_wdata[MV_W-1:0];
                CFG_ABN_VOLT:    abn_reg    <= cfg_wdata[MV_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            it_req_reg   <= req_t'(req_ch.req_type);
            it_adc_reg   <= req_ch.adc_mv;
            it_fail_reg  <= req_ch.adc_fail;
            it_valid_reg <= req_ch.cable_valid;
            it_idx_reg   <= req_ch.entry_index;
            it_min_reg   <= req_ch.entry_min;
            it_max_reg   <= req_ch.entry_max;
            it_type_reg  <= req_ch.entry_type;
        end
    end

    // shared unit operand select
    always_comb
    begin
        cmp_a = '0;
        cmp_b = '0;
        unique case (state_reg)
            S_F_DIFF:
            begin
                cmp_a = it_adc_reg;
                cmp_b = hist_reg[0];
            end
            S_F_CMP:
            begin
                cmp_a = d_reg;
                cmp_b = thr_reg;
            end
            S_C_LOOP:
            begin
                cmp_a = it_adc_reg;
                cmp_b = hist_reg[idx_reg[HIW-1:0]];
            end
            S_C_CMP:
            begin
                cmp_a = thr_reg;
                cmp_b = d_reg;
            end
            S_T_LO:
            begin
                cmp_a = v_reg;
                cmp_b = tbl_rdata.lo;
            end
            S_T_HI:
            begin
                cmp_a = tbl_rdata.hi;
                cmp_b = v_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        meas_next     = meas_reg;
        cnt_next      = cnt_reg;
        att_next      = att_reg;
        cur_type_next = cur_type_reg;
        cur_v_next    = cur_v_reg;
        idx_next      = idx_reg;
        tidx_next     = tidx_reg;
        d_next        = d_reg;
        v_next        = v_reg;
        stat_next     = stat_reg;
        ov_next       = ov_reg && !res_ch.ready;
        o_stat_next   = o_stat_reg;
        o_type_next   = o_type_reg;
        o_v_next      = o_v_reg;
        hist_we       = 1'b0;
        hist_wa       = '0;
        tbl_we        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                state_next = S_IDLE;
                case (it_req_reg)
                    REQ_TABLE:
                    begin
                        tbl_we = ({1'b0, it_idx_reg} < (IDX_W + 1)'(TABLE_DEPTH))
                                 || (TABLE_DEPTH > 7);
                    end
                    REQ_START:
                    begin
                        cnt_next = '0;
                        att_next = '0;
                        if (!it_valid_reg)
                        begin
                            meas_next     = 1'b0;
                            cur_type_next = '0;
                            cur_v_next    = '0;
                            stat_next     = ST_INVALID;
                            state_next    = S_EMIT;
                        end
                        else
                        begin
                            meas_next = 1'b1;
                        end
                    end
                    REQ_SAMPLE:
                    begin
                        if (meas_reg)
                        begin
                            if (cnt_reg == '0 && !it_valid_reg)
                            begin
                                meas_next     = 1'b0;
                                att_next      = '0;
                                cur_type_next = '0;
                                cur_v_next    = '0;
                                stat_next     = ST_INVALID;
                                state_next    = S_EMIT;
                            end
                            else if (it_fail_reg)
                            begin
                                stat_next  = ST_ADCFAIL;
                                state_next = S_FAIL;
                            end
                            else if (!emb_reg)
                            begin
                                v_next     = it_adc_reg;
                                state_next = S_CLASSIFY;
                            end
                            else if (fboot_reg)
                            begin
                                if (!cnt_reg[0])
                                begin
                                    hist_we  = 1'b1;
                                    hist_wa  = '0;
                                    cnt_next = cnt_reg + SCW'(1);
                                end
                                else
                                begin
                                    state_next = S_F_DIFF;
                                end
                            end
                            else
                            begin
                                hist_we    = 1'b1;
                                hist_wa    = cnt_eff[HIW-1:0];
                                cnt_next   = cnt_eff;
                                idx_next   = '0;
                                state_next = S_C_LOOP;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            S_F_DIFF:
            begin
                d_next     = cmp_res.mag;
                state_next = S_F_CMP;
            end

            S_F_CMP:
            begin
                if (cmp_res.lt || ((cnt_reg >> 1) >= SCW'(MAX_SAMPLES - 1)))
                begin
                    v_next     = it_adc_reg;
                    state_next = S_CLASSIFY;
                end
                else
                begin
                    cnt_next   = cnt_reg + SCW'(1);
                    state_next = S_IDLE;
                end
            end

            S_C_LOOP:
            begin
                if (idx_reg == cnt_reg)
                begin
                    cnt_next = cnt_reg + SCW'(1);
                    if (cnt_reg >= SCW'(MAX_SAMPLES - 1))
                    begin
                        v_next     = it_adc_reg;
                        state_next = S_CLASSIFY;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    d_next     = cmp_res.mag;
                    state_next = S_C_CMP;
                end
            end

            S_C_CMP:
            begin
                // threshold below difference: unstable cable
                if (cmp_res.lt)
                begin
                    v_next     = abn_reg;
                    state_next = S_CLASSIFY;
                end
                else
                begin
                    idx_next   = idx_reg + SCW'(1);
                    state_next = S_C_LOOP;
                end
            end

            S_CLASSIFY:
            begin
                if (n_eff == '0)
                begin
                    cur_type_next = '0;
                    cur_v_next    = v_reg;
                    meas_next     = 1'b0;
                    stat_next     = ST_MATCH;
                    state_next    = S_EMIT;
                end
                else
                begin
                    tidx_next  = '0;
                    state_next = S_T_ADDR;
                end
            end

            S_T_ADDR:
            begin
                state_next = S_T_LO;
            end

            S_T_LO,
            S_T_HI:
            begin
                if (cmp_res.lt)
                begin
                    if (tidx_inc == n_eff)
                    begin
                        stat_next  = ST_NOMATCH;
                        state_next = S_FAIL;
                    end
                    else
                    begin
                        tidx_next  = tidx_inc;
                        state_next = S_T_ADDR;
                    end
                end
                else if (state_reg == S_T_LO)
                begin
                    state_next = S_T_HI;
                end
                else
                begin
                    cur_type_next = tbl_rdata.code;
                    cur_v_next    = v_reg;
                    meas_next     = 1'b0;
                    stat_next     = ST_MATCH;
                    state_next    = S_EMIT;
                end
            end

            S_FAIL:
            begin
                cnt_next = '0;
                if (att_inc >= ACW'(RETRY_LIMIT))
                begin
                    meas_next  = 1'b0;
                    att_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    att_next   = att_inc;
                    state_next = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (!ov_reg || res_ch.ready)
                begin
                    ov_next     = 1'b1;
                    o_stat_next = stat_reg;
                    o_type_next = cur_type_reg;
                    o_v_next    = cur_v_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            meas_reg     <= 1'b0;
            cnt_reg      <= '0;
            att_reg      <= '0;
            cur_type_reg <= '0;
            cur_v_reg    <= '0;
            idx_reg      <= '0;
            tidx_reg     <= '0;
            d_reg        <= '0;
            v_reg        <= '0;
            stat_reg     <= ST_MATCH;
            ov_reg       <= 1'b0;
            o_stat_reg   <= ST_MATCH;
            o_type_reg   <= '0;
            o_v_reg      <= '0;
            for (int i = 0; i < MAX_SAMPLES; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            meas_reg     <= meas_next;
            cnt_reg      <= cnt_next;
            att_reg      <= att_next;
            cur_type_reg <= cur_type_next;
            cur_v_reg    <= cur_v_next;
            idx_reg      <= idx_next;
            tidx_reg     <= tidx_next;
            d_reg        <= d_next;
            v_reg        <= v_next;
            stat_reg     <= stat_next;
            ov_reg       <= ov_next;
            o_stat_reg   <= o_stat_next;
            o_type_reg   <= o_type_next;
            o_v_reg      <= o_v_next;
            if (hist_we)
            begin
                hist_reg[hist_wa] <= it_adc_reg;
            end
        end
    end

endmodule

FILE: hdl/acic_checker.sv
module acic_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic [acic_pkg::REQ_W-1:0]    req_type,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [acic_pkg::STAT_W-1:0]   res_status,
    input logic [acic_pkg::TYPE_W-1:0]   res_type,
    input logic [acic_pkg::MV_W-1:0]     res_voltage
);
    import acic_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready high right after an item was taken");

    a_invalid_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == ST_INVALID |-> res_type == '0 && res_voltage == '0)
        else $error("invalid cable result with nonzero type or voltage");

    a_table_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_TABLE
        |=> !$rose(res_valid) ##1 !$rose(res_valid))
        else $error("table write produced a result");

endmodule

bind adc_cable_id_classifier acic_checker u_acic_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_ch.valid),
    .req_ready   (req_ch.ready),
    .req_type    (req_ch.req_type),
    .res_valid   (res_ch.valid),
    .res_ready   (res_ch.ready),
    .res_status  (res_ch.status),
    .res_type    (res_ch.cable_type),
    .res_voltage (res_ch.voltage_mv)
);

FILE: tb/cable_report_checker.sv
module cable_report_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    acic_req_if                             req_ch,
    acic_res_if                             res_ch,
    input  logic                            cfg_we,
    input  logic [acic_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [acic_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fault_count,
    output int                              outstanding
);
    import acic_pkg::*;

    localparam int TABLE_DEPTH = 8;
    localparam int MAX_SAMPLES = 4;
    localparam int RETRY_LIMIT = 3;

    typedef struct packed {
        status_t           status;
        logic [TYPE_W-1:0] cable_type;
        logic [MV_W-1:0]   voltage_mv;
    } report_t;

    report_t pending_reports[$];

    logic [TCNT_W-1:0] table_count;
    logic              emb_batt;
    logic              fact_boot;
    logic [MV_W-1:0]   diff_thr;
    logic [MV_W-1:0]   abn_volt;

    range_entry_t      ranges [TABLE_DEPTH];
    logic [MV_W-1:0]   history [MAX_SAMPLES];
    int unsigned       smp_cnt;
    int unsigned       att_cnt;
    bit                measuring;
    logic [TYPE_W-1:0] cur_type;
    logic [MV_W-1:0]   cur_volt;

    function automatic logic [MV_W-1:0] mv_gap(logic [MV_W-1:0] a, logic [MV_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic post_report(status_t st);
        report_t r;
        r.status     = st;
        r.cable_type = cur_type;
        r.voltage_mv = cur_volt;
        pending_reports.push_back(r);
    endtask

    task automatic end_attempt(status_t st);
        att_cnt++;
        smp_cnt = 0;
        if (att_cnt >= RETRY_LIMIT)
        begin
            measuring = 0;
            att_cnt   = 0;
            post_report(st);
        end
    endtask

    // first matching range wins; empty table means type 0
    task automatic settle(logic [MV_W-1:0] v);
        int n;
        bit hit;
        n   = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count);
        hit = (n == 0);
        if (hit)
            cur_type = '0;
        for (int i = 0; i < n; i++)
        begin
            if (!hit && v >= ranges[i].lo && v <= ranges[i].hi)
            begin
                cur_type = ranges[i].code;
                hit      = 1;
            end
        end
        if (hit)
        begin
            cur_volt  = v;
            measuring = 0;
            post_report(ST_MATCH);
        end
        else
            end_attempt(ST_NOMATCH);
    endtask

    task automatic take_sample(logic [MV_W-1:0] adc, logic fail, logic cv);
        bit unstable;
        unstable = 0;
        if (smp_cnt == 0 && !cv)
        begin
            measuring = 0;
            att_cnt   = 0;
            cur_type  = '0;
            cur_volt  = '0;
            post_report(ST_INVALID);
        end
        else if (fail)
            end_attempt(ST_ADCFAIL);
        else if (!emb_batt)
            settle(adc);
        else if (fact_boot)
        begin
            if (smp_cnt % 2 == 0)
            begin
                history[0] = adc;
                smp_cnt++;
            end
            else if (mv_gap(adc, history[0]) < diff_thr || smp_cnt / 2 + 1 >= MAX_SAMPLES)
                settle(adc);
            else
                smp_cnt++;
        end
        else
        begin
            if (smp_cnt >= MAX_SAMPLES)
                smp_cnt = MAX_SAMPLES - 1;
            history[smp_cnt] = adc;
            for (int i = 0; i < smp_cnt; i++)
            begin
                if (mv_gap(adc, history[i]) > diff_thr)
                    unstable = 1;
            end
            if (unstable)
                settle(abn_volt);
            else
            begin
                smp_cnt++;
                if (smp_cnt >= MAX_SAMPLES)
                    settle(adc);
            end
        end
    endtask

    task automatic take_request();
        case (req_ch.req_type)
            REQ_TABLE:
            begin
                ranges[req_ch.entry_index].lo   = req_ch.entry_min;
                ranges[req_ch.entry_index].hi   = req_ch.entry_max;
                ranges[req_ch.entry_index].code = req_ch.entry_type;
            end
            REQ_START:
            begin
                smp_cnt = 0;
                att_cnt = 0;
                if (!req_ch.cable_valid)
                begin
                    measuring = 0;
                    cur_type  = '0;
                    cur_volt  = '0;
                    post_report(ST_INVALID);
                end
                else
                    measuring = 1;
            end
            REQ_SAMPLE:
            begin
                if (measuring)
                    take_sample(req_ch.adc_mv, req_ch.adc_fail, req_ch.cable_valid);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        report_t want;
        if (!rst_n)
        begin
            pending_reports.delete();
            table_count = '0;
            emb_batt    = 1'b0;
            fact_boot   = 1'b0;
            diff_thr    = DIFF_THR_RST;
            abn_volt    = ABN_V_RST;
            for (int i = 0; i < MAX_SAMPLES; i++)
                history[i] = '0;
            smp_cnt     = 0;
            att_cnt     = 0;
            measuring   = 0;
            cur_type    = '0;
            cur_volt    = '0;
            fault_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected report at %0t: status %0d type %0d mv %0d",
                                 $time, res_ch.status, res_ch.cable_type, res_ch.voltage_mv);
                    fault_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (res_ch.status !== want.status || res_ch.cable_type !== want.cable_type
                        || res_ch.voltage_mv !== want.voltage_mv)
                    begin
                        if (fault_count < 10)
                            $display({"mismatch at %0t: want status %0d type %0d mv %0d,",
                                      " got status %0d type %0d mv %0d"},
                                     $time, want.status, want.cable_type, want.voltage_mv,
                                     res_ch.status, res_ch.cable_type, res_ch.voltage_mv);
                        fault_count++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
                take_request();
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_TABLE_COUNT: table_count = cfg_wdata[TCNT_W-1:0];
                    CFG_EMB_BATT:    emb_batt    = cfg_wdata[0];
                    CFG_FACT_BOOT:   fact_boot   = cfg_wdata[0];
                    CFG_DIFF_THR:    diff_thr    = cfg_wdata[MV_W-1:0];
                    CFG_ABN_VOLT:    abn_volt    = cfg_wdata[MV_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            outstanding = pending_reports.size();
        end
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import acic_pkg::*;

    localparam logic [REQ_W-1:0] REQ_RSVD = 2'd3;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 65;
    localparam int SETTLE      = 64;
    localparam int HOLD_AT     = 300;
    localparam int LONG_HOLD   = 400;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [MV_W-1:0]   adc_mv;
        logic              adc_fail;
        logic              cable_valid;
        logic [IDX_W-1:0]  entry_index;
        logic [MV_W-1:0]   entry_min;
        logic [MV_W-1:0]   entry_max;
        logic [TYPE_W-1:0] entry_type;
    } req_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    faults;
    int                    owed;

    bit                    no_gaps;
    int unsigned           accepted_items;
    int                    counted;
    logic [MV_W-1:0]       last_mv;
    logic [MV_W-1:0]       cur_thr;
    logic [MV_W-1:0]       band_lo [8];
    logic [MV_W-1:0]       band_hi [8];

    acic_req_if req_ch ();
    acic_res_if res_ch ();

    adc_cable_id_classifier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ch    (req_ch),
        .res_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    cable_report_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_ch      (req_ch),
        .res_ch      (res_ch),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .fault_count (faults),
        .outstanding (owed)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic req_item_t mk(logic [REQ_W-1:0] kind, logic [MV_W-1:0] mv,
                                     logic fail, logic cv);
        req_item_t it;
        it.req_type    = kind;
        it.adc_mv      = mv;
        it.adc_fail    = fail;
        it.cable_valid = cv;
        it.entry_index = IDX_W'($urandom);
        it.entry_min   = MV_W'($urandom);
        it.entry_max   = MV_W'($urandom);
        it.entry_type  = TYPE_W'($urandom);
        return it;
    endfunction

    // near the last value, inside a known band, an extreme, or anywhere
    function automatic logic [MV_W-1:0] pick_mv();
        int r;
        int v;
        int b;
        int thr;
        thr = int'(cur_thr);
        r   = $urandom_range(0, 99);
        if (r < 35)
            v = int'(last_mv) - thr - 1 + int'($urandom_range(0, 2 * thr + 2));
        else if (r < 70)
        begin
            b = $urandom_range(0, 7);
            v = $urandom_range(band_lo[b], band_hi[b]);
        end
        else if (r < 78)
            v = $urandom_range(0, 1) ? 4095 : 0;
        else
            v = $urandom_range(0, 4095);
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        last_mv = v[MV_W-1:0];
        return v[MV_W-1:0];
    endfunction

    task automatic offer(req_item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= it.req_type;
        req_ch.adc_mv      <= it.adc_mv;
        req_ch.adc_fail    <= it.adc_fail;
        req_ch.cable_valid <= it.cable_valid;
        req_ch.entry_index <= it.entry_index;
        req_ch.entry_min   <= it.entry_min;
        req_ch.entry_max   <= it.entry_max;
        req_ch.entry_type  <= it.entry_type;
        do
            @(posedge clk);
        while (!req_ch.ready);
        accepted_items++;
        if (it.req_type != REQ_RSVD)
            counted++;
    endtask

    task automatic write_band(logic [IDX_W-1:0] idx, logic [MV_W-1:0] lo, logic [MV_W-1:0] hi,
                              logic [TYPE_W-1:0] code);
        req_item_t it;
        it             = mk(REQ_TABLE, pick_mv(), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
        it.entry_index = idx;
        it.entry_min   = lo;
        it.entry_max   = hi;
        it.entry_type  = code;
        band_lo[idx]   = lo;
        band_hi[idx]   = hi;
        offer(it);
    endtask

    task automatic fresh_band(logic [IDX_W-1:0] idx);
        int lo;
        int hi;
        int t;
        lo = $urandom_range(0, 4095);
        hi = lo + $urandom_range(0, 500);
        if (hi > 4095)
            hi = 4095;
        if ($urandom_range(0, 19) == 0)
        begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        write_band(idx, lo[MV_W-1:0], hi[MV_W-1:0], TYPE_W'($urandom));
    endtask

    task automatic load_settings(int tc, int emb, int fb, int thr, int abn);
        cfg_idx_t              regs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        regs = '{CFG_TABLE_COUNT, CFG_EMB_BATT, CFG_FACT_BOOT, CFG_DIFF_THR, CFG_ABN_VOLT};
        vals = '{tc[CFG_DATA_W-1:0], emb[CFG_DATA_W-1:0], fb[CFG_DATA_W-1:0],
                 thr[CFG_DATA_W-1:0], abn[CFG_DATA_W-1:0]};
        cur_thr = thr[MV_W-1:0];
        cfg_we <= 1'b1;
        for (int k = 0; k < 5; k++)
        begin
            cfg_addr  <= regs[k];
            cfg_wdata <= vals[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // mostly complete measurements, the rest table updates and noise
    task automatic run_sequence();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 72)
        begin
            offer(mk(REQ_START, pick_mv(), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 9) != 0));
            n = $urandom_range(1, 10);
            for (int k = 0; k < n; k++)
                offer(mk(REQ_SAMPLE, pick_mv(), $urandom_range(0, 99) < 6,
                         $urandom_range(0, 99) >= 4));
        end
        else if (r < 77)
        begin
            offer(mk(REQ_START, pick_mv(), 1'b0, 1'b1));
            n = $urandom_range(3, 4);
            for (int k = 0; k < n; k++)
                offer(mk(REQ_SAMPLE, pick_mv(), 1'b1, 1'b1));
        end
        else if (r < 85)
            fresh_band(IDX_W'($urandom_range(0, 7)));
        else if (r < 91)
            offer(mk(REQ_SAMPLE, pick_mv(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1))));
        else if (r < 95)
            offer(mk(REQ_RSVD, pick_mv(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1))));
        else
            offer(mk(REQ_START, pick_mv(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1))));
    endtask

    initial
    begin : result_drain
        int  gap;
        bit  held;
        held = 0;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        res_ch.ready <= 1'b1;
        forever
        begin
            do
                @(posedge clk);
            while (!(res_ch.valid && res_ch.ready));
            gap = no_gaps ? 0 : $urandom_range(0, 8);
            if (!held && accepted_items >= HOLD_AT)
            begin
                held = 1;
                gap  = LONG_HOLD;
            end
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL adc_cable_id_classifier");
        $finish;
    end

    initial
    begin : stimulus
        no_gaps        = 0;
        accepted_items = 0;
        counted        = 0;
        last_mv        = '0;
        cur_thr        = DIFF_THR_RST;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_addr           <= CFG_TABLE_COUNT;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_SAMPLE;
        req_ch.adc_mv      <= '0;
        req_ch.adc_fail    <= 1'b0;
        req_ch.cable_valid <= 1'b0;
        req_ch.entry_index <= '0;
        req_ch.entry_min   <= '0;
        req_ch.entry_max   <= '0;
        req_ch.entry_type  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, single-sample mode
        offer(mk(REQ_START, 12'd0, 1'b0, 1'b1));
        offer(mk(REQ_SAMPLE, 12'd4095, 1'b0, 1'b1));
        offer(mk(REQ_SAMPLE, 12'd0, 1'b0, 1'b1));      // idle, dropped
        offer(mk(REQ_RSVD, 12'd4095, 1'b1, 1'b1));
        offer(mk(REQ_START, 12'd0, 1'b0, 1'b0));       // invalid cable
        offer(mk(REQ_START, 12'd0, 1'b0, 1'b1));
        offer(mk(REQ_SAMPLE, 12'd2048, 1'b0, 1'b0));   // cable gone at first sample
        offer(mk(REQ_START, 12'd0, 1'b0, 1'b1));
        offer(mk(REQ_SAMPLE, 12'd100, 1'b1, 1'b1));
        offer(mk(REQ_START, 12'd0, 1'b0, 1'b1));       // restart mid-measurement
        offer(mk(REQ_SAMPLE, 12'd100, 1'b1, 1'b1));
        offer(mk(REQ_SAMPLE, 12'd200, 1'b1, 1'b1));
        offer(mk(REQ_SAMPLE, 12'd300, 1'b1, 1'b1));    // third failure gives up
        offer(mk(REQ_START, 12'd0, 1'b0, 1'b1));
        offer(mk(REQ_SAMPLE, 12'd0, 1'b0, 1'b1));
        for (int b = 0; b < 7; b++)
            fresh_band(IDX_W'(b));
        write_band(3'd7, 12'd0, 12'd4095, 10'd1023);
        req_ch.valid <= 1'b0;
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: load_settings(8, 0, 0, 100, 1800);
                1: load_settings(15, 1, 1, 0, 0);
                2: load_settings(4, 1, 0, 4095, 4095);
                3: load_settings(1, 1, 1, 4095, 1);
                4: load_settings(8, 1, 0, 60, 2500);
                5: load_settings(0, 1, 0, 30, 100);
                6: load_settings(12, 1, 1, 150, 3000);
                default: load_settings($urandom_range(0, 8), $urandom_range(0, 1),
                                       $urandom_range(0, 1), $urandom_range(0, 300),
                                       $urandom_range(0, 4095));
            endcase
            no_gaps = (p % 3 == 2);
            counted = 0;
            while (counted < PHASE_ITEMS)
                run_sequence();
            req_ch.valid <= 1'b0;
            wait_idle();
        end

        if (faults == 0 && owed == 0)
            $display("PASS adc_cable_id_classifier");
        else
            $display("FAIL adc_cable_id_classifier");
        $finish;
    end

endmodule
